// ===== sv/ppu_pkg.sv =====
`default_nettype none

package ppu_pkg;

    // Palette geometry: two 16-bit entries share one 32-bit row
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_ROWS    = PAL_ENTRIES / 2;
    localparam int ROW_W       = $clog2(PAL_ROWS);
    localparam int IDX_W       = 8;

    // Frame geometry
    localparam int MAX_SIDE = 1024;
    localparam int CFG_W    = 10;
    localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
    localparam int TOTAL_W  = 2 * SIDE_W;
    localparam int COUNT_W  = 20;

    // Stream payload widths
    localparam int WORD_W    = 32;
    localparam int WIDX_W    = 7;
    localparam int IN_DATA_W = ((WORD_W + WIDX_W + 7) / 8) * 8;
    localparam int PIX_W     = 16;
    localparam int POS_W     = $clog2(WORD_W);
    localparam int DEPTH_W   = 3;
    localparam int SHIFT_W   = $clog2(WORD_W);

    typedef enum logic [0:0] {
        OP_PAL_LOAD = 1'b0,
        OP_PIXEL    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_DEPTH  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_2BPP  = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd4;

    // Number of pixels along one side, limited to MAX_SIDE
    function automatic logic [SIDE_W-1:0] side_len(input logic [CFG_W-1:0] minus_one);
        logic [SIDE_W-1:0] s;
        s = SIDE_W'(minus_one) + SIDE_W'(1);
        return (int'(s) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : s;
    endfunction

    // Palette index mask per depth code
    function automatic logic [IDX_W-1:0] idx_mask(input logic [DEPTH_W-1:0] depth);
        logic [IDX_W-1:0] m;
        unique case (depth)
            DEPTH_1BPP: m = IDX_W'(8'h01);
            DEPTH_2BPP: m = IDX_W'(8'h03);
            DEPTH_4BPP: m = IDX_W'(8'h0f);
            default:    m = IDX_W'(8'hff);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/palette_pixel_unpacker.sv =====
// The first pixel of a word passes the work register, read stage and output register to m_tvalid.
// Throughput: one pixel per cycle unless m_tready stalls; a pixel word gives 32, 16, 8 or 4 pixels
// at 1, 2, 4, 8 bpp and 2 pixels at 16 bpp, and the output channel carries one pixel per cycle.
// A palette load or a word at an unused depth code gives no pixel.
// Reset clears the palette valid bits (all entries read as zero), the pixel counter and
// the configuration registers; the block is ready right after reset.
`default_nettype none

module palette_pixel_unpacker
    import ppu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave side
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,   // data_word [31:0], word_index [38:32], zero
    input  wire logic                 s_tuser,   // opcode
    // master side
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,   // pixel [15:0]
    output logic                      m_tlast,   // last_of_word
    output logic                      m_tuser,   // end_of_frame
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [DEPTH_W-1:0] depth_mode_reg;
    logic [CFG_W-1:0]   width_m1_reg;
    logic [CFG_W-1:0]   height_m1_reg;
    logic [TOTAL_W-1:0] total_reg;

    // Work register: the word being unpacked
    logic               work_valid_reg, work_valid_next;
    op_t                work_op_reg, work_op_next;
    logic [WORD_W-1:0]  work_word_reg, work_word_next;
    logic [WIDX_W-1:0]  work_widx_reg, work_widx_next;
    logic [POS_W-1:0]   work_pos_reg, work_pos_next;

    // Pixel counter
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cnt_inc;
    logic               cnt_eof;

    // Palette memory and row valid bits
    logic [2*PIX_W-1:0] pal_mem [PAL_ROWS];
    logic [PAL_ROWS-1:0] pal_valid_reg;
    logic [2*PIX_W-1:0] rd_data_reg;

    // Read stage
    logic               s1_valid_reg;
    logic               s1_direct_reg;
    logic [PIX_W-1:0]   s1_direct_pix_reg;
    logic               s1_sel_reg;
    logic               s1_hit_reg;
    logic               s1_last_reg;
    logic               s1_eof_reg;

    // Output register
    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_pix_reg;
    logic               m_last_reg;
    logic               m_eof_reg;

    // Issue control
    logic               move;
    logic               pix_item;
    logic               pix_last;
    logic [POS_W-1:0]   last_pos;
    logic [SHIFT_W:0]   bpp;
    logic               issue;
    logic               issue_pix;
    logic               issue_done;
    logic               in_take;
    logic [IDX_W-1:0]   pix_idx;
    logic [ROW_W-1:0]   rd_row;
    logic               idx_in_range;
    logic               wr_en;
    logic [ROW_W-1:0]   wr_row;
    logic [PIX_W-1:0]   out_pix;

    // Pipeline advances whenever the output register is free or being drained
    assign move     = !m_valid_reg || m_tready;
    assign pix_item = (work_op_reg == OP_PIXEL) && (depth_mode_reg <= DEPTH_16BPP);
    assign last_pos = POS_W'((WORD_W >> depth_mode_reg) - 1);
    assign pix_last = (work_pos_reg == last_pos);
    assign bpp      = (SHIFT_W + 1)'(1) << depth_mode_reg;

    assign issue      = move && work_valid_reg;
    assign issue_pix  = issue && pix_item;
    assign issue_done = issue && (!pix_item || pix_last);

    // Hold off new words during a configuration transaction
    assign s_tready  = (!work_valid_reg || issue_done) && !cfg_valid;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Palette lookup address
    assign pix_idx      = work_word_reg[IDX_W-1:0] & idx_mask(depth_mode_reg);
    assign rd_row       = pix_idx[ROW_W:1];
    assign idx_in_range = int'(pix_idx) < PAL_ENTRIES;

    // Palette load goes to one row (two entries)
    assign wr_en  = issue && (work_op_reg == OP_PAL_LOAD) && (int'(work_widx_reg) < PAL_ROWS);
    assign wr_row = work_widx_reg[ROW_W-1:0];

    // Frame counter step
    assign cnt_inc = count_reg + COUNT_W'(1);
    assign cnt_eof = (TOTAL_W'(cnt_inc) >= total_reg) || (cnt_inc == '0);

    always_comb
    begin
        count_next = count_reg;
        if (issue_pix) begin
            count_next = cnt_eof ? '0 : cnt_inc;
        end
    end

    // Work register next state
    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_op_next    = work_op_reg;
        work_word_next  = work_word_reg;
        work_widx_next  = work_widx_reg;
        work_pos_next   = work_pos_reg;
        if (in_take) begin
            work_valid_next = 1'b1;
            work_op_next    = op_t'(s_tuser);
            work_word_next  = s_tdata[WORD_W-1:0];
            work_widx_next  = s_tdata[WORD_W+WIDX_W-1:WORD_W];
            work_pos_next   = '0;
        end else if (issue_done) begin
            work_valid_next = 1'b0;
        end else if (issue_pix) begin
            work_word_next = work_word_reg >> bpp;
            work_pos_next  = work_pos_reg + POS_W'(1);
        end
    end

    // Select the pixel leaving the read stage
    always_comb
    begin
        if (s1_direct_reg) begin
            out_pix = s1_direct_pix_reg;
        end else if (!s1_hit_reg) begin
            out_pix = '0;
        end else if (s1_sel_reg) begin
            out_pix = rd_data_reg[2*PIX_W-1:PIX_W];
        end else begin
            out_pix = rd_data_reg[PIX_W-1:0];
        end
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            depth_mode_reg <= '0;
            width_m1_reg   <= '0;
            height_m1_reg  <= '0;
            total_reg      <= TOTAL_W'(1);
            work_valid_reg <= 1'b0;
            count_reg      <= '0;
            pal_valid_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DEPTH:  depth_mode_reg <= cfg_data[DEPTH_W-1:0];
                    REG_WIDTH:  width_m1_reg   <= cfg_data;
                    REG_HEIGHT: height_m1_reg  <= cfg_data;
                    default:    ;
                endcase
            end
            total_reg      <= TOTAL_W'(side_len(width_m1_reg)) *
                              TOTAL_W'(side_len(height_m1_reg));
            work_valid_reg <= work_valid_next;
            count_reg      <= count_next;
            if (wr_en) begin
                pal_valid_reg[wr_row] <= 1'b1;
            end
            if (move) begin
                s1_valid_reg <= issue_pix;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    // Payload registers and palette memory
    always_ff @(posedge clk)
    begin
        work_op_reg   <= work_op_next;
        work_word_reg <= work_word_next;
        work_widx_reg <= work_widx_next;
        work_pos_reg  <= work_pos_next;
        if (wr_en) begin
            pal_mem[wr_row] <= work_word_reg;
        end
        if (issue_pix) begin
            rd_data_reg       <= pal_mem[rd_row];
            s1_direct_reg     <= (depth_mode_reg == DEPTH_16BPP);
            s1_direct_pix_reg <= work_word_reg[PIX_W-1:0];
            s1_sel_reg        <= pix_idx[0];
            s1_hit_reg        <= pal_valid_reg[rd_row] && idx_in_range;
            s1_last_reg       <= pix_last;
            s1_eof_reg        <= cnt_eof;
        end
        if (move && s1_valid_reg) begin
            m_pix_reg  <= out_pix;
            m_last_reg <= s1_last_reg;
            m_eof_reg  <= s1_eof_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eof_reg;

    // End of frame returns the counter to zero
    a_eof_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        issue_pix && cnt_eof |=> count_reg == '0)
        else $error("pixel counter not cleared after end of frame");

    // The last pixel of a word frees the work register or loads a fresh word
    a_last_frees_work: assert property (@(posedge clk) disable iff (!rst_n)
        issue_pix && pix_last |=> !work_valid_reg || work_pos_reg == '0)
        else $error("work register not released after last pixel");

    // A stalled read stage keeps its pixel
    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !move |=> s1_valid_reg && $stable(out_pix))
        else $error("read stage changed under stall");

    // Palette row valid bits never clear outside reset
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (pal_valid_reg & $past(pal_valid_reg)) == $past(pal_valid_reg))
        else $error("palette valid bit cleared");

endmodule

`default_nettype wire

// ===== dv/palette_pixel_unpacker_tb.sv =====
`default_nettype none

module palette_pixel_unpacker_tb;
    import ppu_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int N_DIRECTED    = 33;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 25;
    localparam int PHASE_CAP     = 40;

    // Depth codes with no pixel output
    localparam logic [DEPTH_W-1:0] DEPTH_RSVD5 = 3'd5;
    localparam logic [DEPTH_W-1:0] DEPTH_RSVD6 = 3'd6;
    localparam logic [DEPTH_W-1:0] DEPTH_RSVD7 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             eof;
    } pix_beat_t;

    typedef struct packed {
        logic             is_cfg;
        cfg_reg_t         reg_sel;
        logic [CFG_W-1:0] value;
        op_t              op;
        logic [31:0]      word;
        logic [6:0]       widx;
        logic             typed;
        logic [5:0]       n_pix;
        logic [15:0]      pix;
        logic             eof;
    } step_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = 2'b00;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predictor state: palette copy, frame position and register copies
    logic [15:0]          pal_mirror [256];
    logic [19:0]          frame_pos;
    logic [DEPTH_W-1:0]   cur_depth;
    logic [CFG_W-1:0]     cur_wm1;
    logic [CFG_W-1:0]     cur_hm1;
    pix_beat_t            pix_expect_q [$];

    int                   mismatches     = 0;
    int                   cycle_cnt      = 0;
    int                   src_idle_pct   = 0;
    int                   sink_stall_pct = 0;
    logic                 hold_go        = 1'b0;
    int                   hold_cnt       = 0;
    step_t                directed [N_DIRECTED];

    palette_pixel_unpacker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive the receiver: random stalls, plus one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_go && hold_cnt < HOLD_CYCLES)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each output transaction with the oldest expected pixel
    always @(posedge clk)
    begin
        pix_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pix_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h last %b eof %b", m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = pix_expect_q.pop_front();
                if (want.pixel !== m_tdata || want.last !== m_tlast || want.eof !== m_tuser)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.pixel, want.last, want.eof, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    function automatic step_t cfg_row(input cfg_reg_t sel, input int unsigned val);
        step_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.value   = CFG_W'(val);
        return r;
    endfunction

    function automatic step_t item_row(input op_t op, input logic [31:0] word,
                                       input logic [6:0] widx);
        step_t r;
        r = '0;
        r.op   = op;
        r.word = word;
        r.widx = widx;
        return r;
    endfunction

    // Item whose pixels are all equal and can be written down directly
    function automatic step_t typed_row(input op_t op, input logic [31:0] word,
                                        input logic [6:0] widx, input int n,
                                        input logic [15:0] pix, input logic eof);
        step_t r;
        r = item_row(op, word, widx);
        r.typed = 1'b1;
        r.n_pix = 6'(n);
        r.pix   = pix;
        r.eof   = eof;
        return r;
    endfunction

    // Advance the frame position by one pixel and record the pixel
    function automatic void emit_pixel(input logic [15:0] pix, input logic last, input bit keep);
        logic [10:0] w_len;
        logic [10:0] h_len;
        logic [20:0] total;
        logic [19:0] nxt;
        logic        eof;
        // a 10-bit side plus one never exceeds the maximum side
        w_len = {1'b0, cur_wm1} + 11'd1;
        h_len = {1'b0, cur_hm1} + 11'd1;
        total = w_len * h_len;
        nxt   = frame_pos + 20'd1;
        eof   = ({1'b0, nxt} >= total) || (nxt == '0);
        if (eof)
            nxt = '0;
        frame_pos = nxt;
        if (keep)
            pix_expect_q.push_back('{pix, last, eof});
    endfunction

    // Work out the pixels of one accepted word
    function automatic void unpack_word(input op_t op, input logic [31:0] word,
                                        input logic [6:0] widx, input bit keep);
        int         bits;
        int         count;
        logic [7:0] idx;
        // word_index tops out at 127, so both halves always land in the store
        if (op == OP_PAL_LOAD)
        begin
            pal_mirror[{widx, 1'b0}] = word[15:0];
            pal_mirror[{widx, 1'b1}] = word[31:16];
            return;
        end
        case (cur_depth)
            DEPTH_1BPP: bits = 1;
            DEPTH_2BPP: bits = 2;
            DEPTH_4BPP: bits = 4;
            DEPTH_8BPP: bits = 8;
            DEPTH_16BPP:
            begin
                emit_pixel(word[15:0], 1'b0, keep);
                emit_pixel(word[31:16], 1'b1, keep);
                return;
            end
            default: return;
        endcase
        count = 32 / bits;
        for (int i = 0; i < count; i++)
        begin
            idx = 8'((word >> (i * bits)) & ((32'd1 << bits) - 32'd1));
            emit_pixel(pal_mirror[idx], i == count - 1, keep);
        end
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 87; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 87; end
            default:       begin src_idle_pct = 32; sink_stall_pct = 32; end
        endcase
    endfunction

    // Wait until every expected pixel is out, then let in-flight loads finish
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pix_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (sel)
            REG_DEPTH:  cur_depth = val[DEPTH_W-1:0];
            REG_WIDTH:  cur_wm1   = val;
            REG_HEIGHT: cur_hm1   = val;
            default:    ;
        endcase
    endtask

    // Offer one word, optionally after a random gap, and predict once accepted
    task automatic send_word(input op_t op, input logic [31:0] word,
                             input logic [6:0] widx, input bit keep);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({widx, word});
        do @(posedge clk); while (!s_tready);
        unpack_word(op, word, widx, keep);
    endtask

    initial
    begin
        step_t      row;
        int         n_useful;
        int         n_sent;
        op_t        op;
        logic [31:0] word;
        logic [9:0] wm1;
        logic [9:0] hm1;
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] used_depths [5];

        used_depths = '{DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_8BPP, DEPTH_16BPP};
        for (int i = 0; i < 256; i++)
            pal_mirror[i] = '0;
        frame_pos = '0;
        cur_depth = DEPTH_1BPP;
        cur_wm1   = '0;
        cur_hm1   = '0;

        directed = '{
            // reset state: 1bpp, 1x1 frame, palette all zero
            typed_row(OP_PIXEL,    32'hFFFF_FFFF, 7'd0,   32, 16'h0000, 1'b1),
            typed_row(OP_PAL_LOAD, 32'hBEEF_1234, 7'd0,   0,  16'h0000, 1'b0),
            item_row (OP_PIXEL,    32'hAAAA_5555, 7'd127),
            cfg_row  (REG_DEPTH, DEPTH_2BPP),
            typed_row(OP_PAL_LOAD, 32'h0F0F_F0F0, 7'd1,   0,  16'h0000, 1'b0),
            item_row (OP_PIXEL,    32'hE4E4_E4E4, 7'd0),
            cfg_row  (REG_DEPTH, DEPTH_4BPP),
            typed_row(OP_PAL_LOAD, 32'hFFFF_0000, 7'd7,   0,  16'h0000, 1'b0),
            item_row (OP_PIXEL,    32'hFEDC_BA98, 7'd0),
            cfg_row  (REG_DEPTH, DEPTH_8BPP),
            typed_row(OP_PAL_LOAD, 32'hCAFE_F00D, 7'd127, 0,  16'h0000, 1'b0),
            item_row (OP_PIXEL,    32'hFFFE_0100, 7'd0),
            // 16bpp passes halves through; 1x1 frame ends on every pixel
            cfg_row  (REG_DEPTH, DEPTH_16BPP),
            typed_row(OP_PIXEL,    32'hFFFF_FFFF, 7'd0,   2,  16'hFFFF, 1'b1),
            typed_row(OP_PIXEL,    32'h0000_0000, 7'd0,   2,  16'h0000, 1'b1),
            // unused depth codes give nothing
            cfg_row  (REG_DEPTH, DEPTH_RSVD5),
            typed_row(OP_PIXEL,    32'h1234_5678, 7'd0,   0,  16'h0000, 1'b0),
            cfg_row  (REG_DEPTH, DEPTH_RSVD7),
            typed_row(OP_PIXEL,    32'hFFFF_FFFF, 7'd0,   0,  16'h0000, 1'b0),
            cfg_row  (REG_DEPTH, DEPTH_RSVD6),
            typed_row(OP_PIXEL,    32'h0000_0000, 7'd0,   0,  16'h0000, 1'b0),
            typed_row(OP_PAL_LOAD, 32'h8001_7FFE, 7'd64,  0,  16'h0000, 1'b0),
            // largest frame, then shrink it below the current position
            cfg_row  (REG_WIDTH, 1023),
            cfg_row  (REG_HEIGHT, 1023),
            cfg_row  (REG_DEPTH, DEPTH_16BPP),
            item_row (OP_PIXEL,    32'h89AB_CDEF, 7'd0),
            item_row (OP_PIXEL,    32'h7777_1111, 7'd0),
            item_row (OP_PIXEL,    32'h00FF_FF00, 7'd0),
            cfg_row  (REG_WIDTH, 2),
            cfg_row  (REG_HEIGHT, 0),
            item_row (OP_PIXEL,    32'h1357_9BDF, 7'd0),
            cfg_row  (REG_DEPTH, DEPTH_1BPP),
            item_row (OP_PIXEL,    32'h0000_FFFF, 7'd0)
        };

        set_idle(IDLE_BOTH);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed[i];
            if (row.is_cfg)
                write_reg(row.reg_sel, row.value);
            else
            begin
                send_word(row.op, row.word, row.widx, !row.typed);
                for (int k = 0; k < row.n_pix; k++)
                    pix_expect_q.push_back('{row.pix, k == row.n_pix - 1, row.eof});
            end
        end

        // Random phases, each with its own setting and one of four idle patterns
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_idle(idle_mode_t'(p % 4));
            depth = (p < 5) ? used_depths[p] : DEPTH_W'($urandom_range(DEPTH_RSVD7));
            case (p)
                0:       begin wm1 = 10'd0;    hm1 = 10'd0;    end
                1:       begin wm1 = 10'd1023; hm1 = 10'd1023; end
                2:       begin wm1 = 10'd1023; hm1 = 10'd0;    end
                7:       begin wm1 = 10'($urandom_range(1023)); hm1 = 10'($urandom_range(1023)); end
                default: begin wm1 = 10'($urandom_range(15));   hm1 = 10'($urandom_range(3));    end
            endcase
            write_reg(REG_DEPTH, 10'(depth));
            write_reg(REG_WIDTH, wm1);
            write_reg(REG_HEIGHT, hm1);

            // stall the output for a long stretch while words keep coming
            if (p == 0)
                hold_go <= 1'b1;

            n_useful = 0;
            n_sent   = 0;
            while (n_useful < PHASE_ITEMS && n_sent < PHASE_CAP)
            begin
                op = ($urandom_range(4) == 0) ? OP_PAL_LOAD : OP_PIXEL;
                case ($urandom_range(9))
                    0:       word = 32'h0000_0000;
                    1:       word = 32'hFFFF_FFFF;
                    default: word = $urandom();
                endcase
                send_word(op, word, 7'($urandom_range(127)), 1'b1);
                n_sent++;
                if (op == OP_PAL_LOAD || cur_depth <= DEPTH_16BPP)
                    n_useful++;
            end
        end

        settle_block();
        if (mismatches == 0 && pix_expect_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
